// ----- hdl/lkvc_pkg.sv -----
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] store_value;
  } in_item_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } cell_entry_t;

  typedef struct packed {
    logic             cmp;
    logic             upd_hit;
    logic             upd_ins;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

// ----- hdl/lkvc_cell.sv -----
module lkvc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lkvc_pkg::cell_ctl_t   ctl,
  input  lkvc_pkg::cell_entry_t prev_ent,
  input  logic                  keep,
  input  logic                  tail_hit_in,
  output lkvc_pkg::cell_entry_t ent,
  output logic                  hit,
  output logic                  tail_hit_out
);
  import lkvc_pkg::*;

  logic             vld_r, vld_nxt;
  logic             hit_r, hit_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;

  assign tail_hit_out = hit_r | tail_hit_in;
  assign hit = hit_r;
  assign ent = '{vld: vld_r, key: key_r, val: val_r};

  always_comb begin
    vld_nxt = vld_r;
    hit_nxt = hit_r;
    key_nxt = key_r;
    val_nxt = val_r;
    if (ctl.cmp) begin
      hit_nxt = vld_r && (key_r == ctl.key);
    end
    if (ctl.upd_hit && tail_hit_out) begin
      vld_nxt = prev_ent.vld;
      key_nxt = prev_ent.key;
      val_nxt = prev_ent.val;
    end
    if (ctl.upd_ins) begin
      vld_nxt = prev_ent.vld & keep;
      key_nxt = prev_ent.key;
      val_nxt = prev_ent.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

// ----- hdl/lru_key_value_cache.sv -----
// A get result is registered when its update step commits, after the compare step.
// Each item takes a key compare in every cell, then a recency shift along the cell
// row; the next item is accepted no earlier than the commit of the last one.
// A waiting result that is not taken holds back the next get's update.
// Reset clears all valid marks and sets capacity to 16; there is no clearing pass.
module lru_key_value_cache (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lkvc_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lkvc_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkvc_pkg::DATA_W-1:0]   pwdata,
  output logic [lkvc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t           state_r, state_nxt;
  logic             req_op_r, req_op_nxt;
  logic [KEY_W-1:0] req_key_r, req_key_nxt;
  logic [VAL_W-1:0] req_val_r, req_val_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_eff;

  cell_entry_t      ent_vec [ENTRIES];
  cell_entry_t      head_ent;
  cell_ctl_t        ctl;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] vld_vec;
  logic [ENTRIES-1:0] keep_vec;
  logic [ENTRIES-1:0] tail_out;
  logic [ENTRIES-1:0] tail_in;
  logic [VAL_W-1:0] hit_val;
  logic             any_hit;
  logic             blocked;
  logic             commit;
  logic             accept;
  logic             cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (paddr[ADDR_W-1] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_CAPACITY) ? DATA_W'(cap_r) : '0;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > CAP_W'(ENTRIES)) begin
      cap_eff = CAP_W'(ENTRIES);
    end else begin
      cap_eff = cap_r;
    end
  end

  // Cell row: cell 0 holds the most recent entry.
  genvar i;
  generate
    for (i = 0; i < ENTRIES; i++) begin : g_cell
      cell_entry_t prev;
      if (i == 0) begin : g_head
        assign prev = head_ent;
      end else begin : g_link
        assign prev = ent_vec[i-1];
      end
      if (i == ENTRIES - 1) begin : g_last
        assign tail_in[i] = 1'b0;
      end else begin : g_mid
        assign tail_in[i] = tail_out[i+1];
      end
      assign keep_vec[i] = (CAP_W'(i) < cap_eff);
      assign vld_vec[i] = ent_vec[i].vld;

      lkvc_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .prev_ent     (prev),
        .keep         (keep_vec[i]),
        .tail_hit_in  (tail_in[i]),
        .ent          (ent_vec[i]),
        .hit          (hit_vec[i]),
        .tail_hit_out (tail_out[i])
      );
    end
  endgenerate

  always_comb begin
    hit_val = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      hit_val = hit_val | ({VAL_W{hit_vec[k]}} & ent_vec[k].val);
    end
  end

  assign any_hit = |hit_vec;
  assign blocked = (req_op_r == OP_GET) && out_valid_r && out_stall;
  assign commit  = (state_r == S_UPD) && !blocked;
  assign in_stall = !((state_r == S_IDLE) || commit);
  assign accept  = in_valid && !in_stall;

  assign head_ent = '{vld: 1'b1, key: req_key_r,
                      val: (req_op_r == OP_PUT) ? req_val_r : hit_val};

  assign ctl = '{cmp: (state_r == S_CMP),
                 upd_hit: commit && any_hit,
                 upd_ins: commit && (req_op_r == OP_PUT) && !any_hit,
                 key: req_key_r};

  always_comb begin
    state_nxt     = state_r;
    req_op_nxt    = req_op_r;
    req_key_nxt   = req_key_r;
    req_val_nxt   = req_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (commit) begin
          state_nxt = accept ? S_CMP : S_IDLE;
          if (req_op_r == OP_GET) begin
            out_valid_nxt = 1'b1;
            out_item_nxt.found = any_hit;
            out_item_nxt.read_value = any_hit ? $signed(hit_val) : '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (accept) begin
      req_op_nxt  = in_item.opcode;
      req_key_nxt = $unsigned(in_item.lookup_key);
      req_val_nxt = $unsigned(in_item.store_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      req_op_r    <= req_op_nxt;
      req_key_r   <= req_key_nxt;
      req_val_r   <= req_val_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Valid entries always form an unbroken run from the head of the row.
  a_vld_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (((vld_vec >> 1) & ~vld_vec) == '0))
    else $error("valid entries are not contiguous");

  // A key is held by at most one valid cell.
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  // A committed put leaves its key at the head of the row.
  a_put_head: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (req_op_r == OP_PUT)) |=> (ent_vec[0].vld && (ent_vec[0].key == $past(req_key_r))))
    else $error("put did not land in the head cell");

  // A result appears only from a committed get.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(commit && (req_op_r == OP_GET)))
    else $error("result without a committed get");

endmodule

// ----- tb/tb_lru_key_value_cache.sv -----
`timescale 1ns / 100ps

module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int POOL_SIZE = 40;
  localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * REG_CAPACITY);
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic [KEY_W-1:0] cache_key [ENTRIES];
  logic [VAL_W-1:0] cache_val [ENTRIES];
  bit cache_vld [ENTRIES];
  int unsigned cache_rank [ENTRIES];
  int unsigned cache_count = 0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  out_item_t pending_reads [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int mismatches = 0;
  int in_idle_pct = 24;
  int out_stall_pct = 24;
  int hold_req = 0;
  int hold_left = 0;

  lru_key_value_cache u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic void make_newest(int s);
    int unsigned r;
    r = cache_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_vld[i] && cache_rank[i] < r) begin
        cache_rank[i]++;
      end
    end
    cache_rank[s] = 0;
  endfunction

  function automatic void store_new(logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    int unsigned lim;
    int victim;
    int unsigned oldest;
    int slot;
    lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
    while (cache_count >= lim && cache_count > 0) begin
      victim = -1;
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (cache_vld[i] && (victim < 0 || cache_rank[i] >= oldest)) begin
          victim = i;
          oldest = cache_rank[i];
        end
      end
      if (victim < 0) begin
        break;
      end
      cache_vld[victim] = 1'b0;
      cache_rank[victim] = 0;
      cache_count--;
    end
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!cache_vld[i] && slot < 0) begin
        slot = i;
      end
    end
    if (slot < 0) begin
      return;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_vld[i]) begin
        cache_rank[i]++;
      end
    end
    cache_key[slot] = key;
    cache_val[slot] = val;
    cache_vld[slot] = 1'b1;
    cache_rank[slot] = 0;
    cache_count++;
  endfunction

  function automatic bit cache_step(in_item_t it, output out_item_t res);
    int hit;
    hit = -1;
    res = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_vld[i] && cache_key[i] == it.lookup_key && hit < 0) begin
        hit = i;
      end
    end
    if (it.opcode == OP_GET) begin
      if (hit >= 0) begin
        make_newest(hit);
        res.found = 1'b1;
        res.read_value = cache_val[hit];
      end
      return 1'b1;
    end
    if (hit >= 0) begin
      cache_val[hit] = it.store_value;
      make_newest(hit);
    end else begin
      store_new(it.lookup_key, it.store_value);
    end
    return 1'b0;
  endfunction

  function automatic in_item_t mk_item(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    in_item_t it;
    it.opcode = op;
    it.lookup_key = key;
    it.store_value = val;
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected result", 64'(0), 64'(out_item));
      end else begin
        exp_r = pending_reads.pop_front();
        if (out_item.found !== exp_r.found) begin
          report_mismatch("found", 64'(exp_r.found), 64'(out_item.found));
        end
        if (out_item.read_value !== exp_r.read_value) begin
          report_mismatch("read_value", 64'(exp_r.read_value), 64'(out_item.read_value));
        end
      end
    end
  end

  task automatic send_item(input in_item_t it);
    out_item_t res;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (cache_step(it, res)) begin
      pending_reads.push_back(res);
    end
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rdata;
    drain();
    cfg_access(1'b1, addr, data, rdata);
    if (addr[ADDR_W-1:2] == REG_CAPACITY) begin
      cap_reg = data[CAP_W-1:0];
    end
    cfg_access(1'b0, CAP_ADDR, '0, rdata);
    if (rdata !== DATA_W'(cap_reg)) begin
      report_mismatch("capacity readback", 64'(cap_reg), 64'(rdata));
    end
  endtask

  task automatic run_traffic(int n, int pool, int put_pct);
    in_item_t it;
    repeat (n) begin
      it.opcode = ($urandom_range(99) < put_pct) ? OP_PUT : OP_GET;
      it.lookup_key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool - 1)];
      it.store_value = $urandom;
      send_item(it);
    end
  endtask

  task automatic test_directed();
    logic [31:0] kmin;
    logic [31:0] kmax;
    kmin = 32'h8000_0000;
    kmax = 32'h7fff_ffff;
    send_item(mk_item(OP_GET, kmin, $urandom));
    send_item(mk_item(OP_PUT, kmin, kmax));
    send_item(mk_item(OP_PUT, kmax, kmin));
    send_item(mk_item(OP_PUT, 32'h0, 32'hffff_ffff));
    send_item(mk_item(OP_PUT, 32'hffff_ffff, 32'h0));
    send_item(mk_item(OP_GET, kmin, 32'hffff_ffff));
    send_item(mk_item(OP_GET, kmax, $urandom));
    send_item(mk_item(OP_GET, 32'h0, $urandom));
    send_item(mk_item(OP_GET, 32'hffff_ffff, $urandom));
    send_item(mk_item(OP_PUT, kmax, 32'h5a5a_a5a5));
    send_item(mk_item(OP_GET, kmax, $urandom));
    send_item(mk_item(OP_GET, 32'h1, $urandom));
    send_item(mk_item(OP_GET, kmin, 32'h0));
    drain();
  endtask

  task automatic test_capacity_sweep();
    int caps [9] = '{16, 1, 0, 2, 31, 17, 16, 3, 8};
    int lim;
    foreach (caps[i]) begin
      write_cfg(CAP_ADDR, DATA_W'(caps[i]));
      lim = (caps[i] == 0) ? 1 : ((caps[i] > ENTRIES) ? ENTRIES : caps[i]);
      run_traffic(120, (lim + 4 > POOL_SIZE) ? POOL_SIZE : lim + 4, 50);
    end
    write_cfg(UNUSED_ADDR, DATA_W'(1));
    write_cfg(UNUSED_ADDR, '1);
  endtask

  task automatic test_backpressure();
    write_cfg(CAP_ADDR, DATA_W'(ENTRIES));
    in_idle_pct = 0;
    hold_req = 400;
    run_traffic(80, 20, 30);
    in_idle_pct = 24;
    drain();
  endtask

  task automatic test_full_rate();
    write_cfg(CAP_ADDR, DATA_W'(12));
    in_idle_pct = 0;
    out_stall_pct = 0;
    run_traffic(200, 18, 50);
    in_idle_pct = 24;
    out_stall_pct = 24;
    drain();
  endtask

  task automatic test_random_settings();
    int c;
    repeat (4) begin
      c = $urandom_range(0, 31);
      write_cfg(CAP_ADDR, DATA_W'(c));
      run_traffic(60, $urandom_range(4, POOL_SIZE), $urandom_range(20, 80));
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity_sweep();
    test_backpressure();
    test_full_rate();
    test_random_settings();
    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lkvc_pkg.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache.sv
tb/tb_lru_key_value_cache.sv
